// ===== src/supply_power_mode_governor_defines.svh =====
`ifndef SUPPLY_POWER_MODE_GOVERNOR_DEFINES_SVH
`define SUPPLY_POWER_MODE_GOVERNOR_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SPMG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmg check failed");

// next-cycle implication, off while reset is held
`define SPMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmg check failed");

// next-cycle implication, also checked across reset
`define SPMG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spmg check failed");

`endif

// ===== src/spmg_pkg.sv =====
package spmg_pkg;

    localparam int VOLT_W  = 16;
    localparam int TEMP_W  = 10;
    localparam int LEVEL_W = 10;
    localparam int STEP_W  = 7;
    localparam int MODE_W  = 2;
    localparam int THR_W   = 14;
    localparam int KS_W    = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_D = 2'd0,
        MODE_C = 2'd1,
        MODE_B = 2'd2,
        MODE_A = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_VOLTAGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_LIMIT = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_RST    = 10'd36;
    localparam logic [STEP_W-1:0]  STEP_RST     = 7'd1;
    localparam logic [VOLT_W-1:0]  FALLBACK_RST = 16'd420;
    localparam logic [MODE_W-1:0]  MAX_MODE_RST = 2'd3;
    localparam logic [TEMP_W-1:0]  TEMP_LIM_RST = 10'd512;

    localparam logic [VOLT_W-1:0] FAIL_LIMIT = 16'd100;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_sample;
        logic              temp_present;
        logic [TEMP_W-1:0] temp_sample;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] threshold_level;
        logic [STEP_W-1:0]  threshold_step;
        logic [VOLT_W-1:0]  fallback_voltage;
        logic [MODE_W-1:0]  max_mode;
        logic [TEMP_W-1:0]  temperature_limit;
    } t_cfg;

    typedef struct packed {
        logic [THR_W-1:0] below0;
        logic [THR_W-1:0] below1;
        logic [THR_W-1:0] below2;
        logic [THR_W-1:0] below3;
        logic [THR_W-1:0] above1;
    } t_thr;

    typedef struct packed {
        t_mode power_mode;
        logic  kill_tx;
        logic  counters_clear;
        logic  over_temp;
    } t_result;

    function automatic t_mode clamp_mode(t_mode req, logic [MODE_W-1:0] max_mode);
        return (req > max_mode) ? t_mode'(max_mode) : req;
    endfunction

    localparam t_mode MODE_RST = clamp_mode(MODE_A, MAX_MODE_RST);

endpackage

// ===== src/spmg_cfg_regs.sv =====
module spmg_cfg_regs
    import spmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_level   <= LEVEL_RST;
            r_cfg.threshold_step    <= STEP_RST;
            r_cfg.fallback_voltage  <= FALLBACK_RST;
            r_cfg.max_mode          <= MAX_MODE_RST;
            r_cfg.temperature_limit <= TEMP_LIM_RST;
        end else if (i_we) begin
            unique case (i_index)
                CFG_THRESHOLD_LEVEL:   r_cfg.threshold_level   <= i_data[LEVEL_W-1:0];
                CFG_THRESHOLD_STEP:    r_cfg.threshold_step    <= i_data[STEP_W-1:0];
                CFG_FALLBACK_VOLTAGE:  r_cfg.fallback_voltage  <= i_data[VOLT_W-1:0];
                CFG_MAX_MODE:          r_cfg.max_mode          <= i_data[MODE_W-1:0];
                CFG_TEMPERATURE_LIMIT: r_cfg.temperature_limit <= i_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/spmg_thresholds.sv =====
module spmg_thresholds
    import spmg_pkg::*;
(
    input  t_cfg i_cfg,
    output t_thr o_thr
);

    logic [KS_W-1:0]    s1;
    logic [KS_W-1:0]    s2;
    logic [KS_W-1:0]    s3;
    logic [LEVEL_W:0]   up1;

    function automatic logic [THR_W-1:0] times_ten(logic [LEVEL_W:0] x);
        logic [THR_W-1:0] xe;
        xe = {{(THR_W-LEVEL_W-1){1'b0}}, x};
        return (xe << 3) + (xe << 1);
    endfunction

    function automatic logic [THR_W-1:0] sat_below(logic [LEVEL_W-1:0] t,
                                                  logic [KS_W-1:0] ks);
        logic [LEVEL_W-1:0] ke;
        logic [LEVEL_W-1:0] d;
        ke = {{(LEVEL_W-KS_W){1'b0}}, ks};
        d  = t - ke;
        return (ke > t) ? '0 : times_ten({1'b0, d});
    endfunction

    assign s1  = {2'b00, i_cfg.threshold_step};
    assign s2  = {1'b0, i_cfg.threshold_step, 1'b0};
    assign s3  = s2 + s1;
    assign up1 = {1'b0, i_cfg.threshold_level} + {{(LEVEL_W+1-STEP_W){1'b0}}, i_cfg.threshold_step};

    assign o_thr.below0 = times_ten({1'b0, i_cfg.threshold_level});
    assign o_thr.below1 = sat_below(i_cfg.threshold_level, s1);
    assign o_thr.below2 = sat_below(i_cfg.threshold_level, s2);
    assign o_thr.below3 = sat_below(i_cfg.threshold_level, s3);
    assign o_thr.above1 = times_ten(up1);

endmodule

// ===== src/spmg_ladder.sv =====
module spmg_ladder
    import spmg_pkg::*;
(
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  t_thr    i_thr,
    input  t_mode   i_mode,
    input  logic    i_over_temp,
    output t_result o_result
);

    logic              ot;
    t_mode             mode_pre;
    t_mode             mode_out;
    t_mode             req;
    logic              req_valid;
    logic              clr;
    logic              kill;
    logic [VOLT_W-1:0] v;

    always_comb begin
        ot       = i_over_temp;
        mode_pre = i_mode;
        clr      = 1'b0;
        kill     = 1'b0;
        req      = MODE_D;
        req_valid = 1'b0;

        // fresh temperature word updates the flag, a hot amplifier drops to D
        if (i_item.temp_present) begin
            ot = i_item.temp_sample > i_cfg.temperature_limit;
            if (ot) begin
                mode_pre = MODE_D;
                clr      = 1'b1;
            end
        end

        // failed reading
        v = (i_item.voltage_sample < FAIL_LIMIT) ? i_cfg.fallback_voltage
                                                 : i_item.voltage_sample;

        if (v < {2'b00, i_thr.below3}) begin
            req_valid = 1'b1;
            req       = MODE_D;
            kill      = 1'b1;
        end else begin
            unique case (mode_pre)
                MODE_A: begin
                    if (v < {2'b00, i_thr.below0}) begin
                        req_valid = 1'b1;
                        req       = MODE_B;
                    end
                end
                MODE_B: begin
                    if (v < {2'b00, i_thr.below1}) begin
                        req_valid = 1'b1;
                        req       = MODE_C;
                    end else if (v > {2'b00, i_thr.above1}) begin
                        req_valid = 1'b1;
                        req       = MODE_A;
                    end
                end
                MODE_C: begin
                    if (v < {2'b00, i_thr.below2}) begin
                        req_valid = 1'b1;
                        req       = MODE_D;
                    end else if (v > {2'b00, i_thr.below0}) begin
                        req_valid = 1'b1;
                        req       = MODE_B;
                    end
                end
                MODE_D: begin
                    if (v > {2'b00, i_thr.below1} && !ot) begin
                        req_valid = 1'b1;
                        req       = MODE_C;
                    end
                end
            endcase
        end

        mode_out = mode_pre;
        if (req_valid) begin
            mode_out = clamp_mode(req, i_cfg.max_mode);
            if (mode_out == MODE_D) begin
                clr = 1'b1;
            end
        end

        o_result.power_mode     = mode_out;
        o_result.kill_tx        = kill;
        o_result.counters_clear = clr;
        o_result.over_temp      = ot;
    end

endmodule

// ===== src/supply_power_mode_governor.sv =====
// Battery supervision governor: one check word in, one mode word out.
// Input channel: i_in_valid / o_in_stall with voltage, temp_present and
// temp_sample; a word is taken on a clock edge with valid high, stall low.
// Output channel: o_out_valid / i_out_stall with power_mode, kill_tx,
// counters_clear and over_temp, one result word per check word.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), register index
// 0..4 on i_cfg_index, value on i_cfg_data; other indexes are ignored.
// Write registers only while no check is in flight.
// Path: a taken word goes to the input register, then the output register.
// Throughput: one check per cycle while not stalled; the mode and
// over-temperature registers are updated in the same cycle the result
// register loads, so back-to-back checks see the previous result's state.
// Stall: a stalled result holds in the output register; one more word is
// held in the input register, then o_in_stall rises.
// Reset (synchronous, active low): both stages empty, registers to their
// defaults, mode A clamped to max_mode, over-temperature flag cleared.
module supply_power_mode_governor
    import spmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VOLT_W-1:0]     i_voltage_sample,
    input  logic                  i_temp_present,
    input  logic [TEMP_W-1:0]     i_temp_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MODE_W-1:0]     o_power_mode,
    output logic                  o_kill_tx,
    output logic                  o_counters_clear,
    output logic                  o_over_temp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_thr    thr;
    t_result result;

    logic    r_s1_valid;
    logic    n_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_mode   r_mode;
    logic    r_over_temp;

    logic    out_free;
    logic    s1_move;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    spmg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    spmg_thresholds u_thresholds (
        .i_cfg (cfg),
        .o_thr (thr)
    );

    spmg_ladder u_ladder (
        .i_item      (r_s1_item),
        .i_cfg       (cfg),
        .i_thr       (thr),
        .i_mode      (r_mode),
        .i_over_temp (r_over_temp),
        .o_result    (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_RST;
            r_over_temp <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_move) begin
                r_mode      <= result.power_mode;
                r_over_temp <= result.over_temp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.voltage_sample <= i_voltage_sample;
            r_s1_item.temp_present   <= i_temp_present;
            r_s1_item.temp_sample    <= i_temp_sample;
        end
        if (s1_move) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_power_mode     = r_out.power_mode;
    assign o_kill_tx        = r_out.kill_tx;
    assign o_counters_clear = r_out.counters_clear;
    assign o_over_temp      = r_out.over_temp;

endmodule

// ===== src/spmg_checker.sv =====
`include "supply_power_mode_governor_defines.svh"

module spmg_checker
    import spmg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MODE_W-1:0] o_power_mode,
    input logic              o_kill_tx,
    input logic              o_counters_clear,
    input logic              o_over_temp
);

    logic [MODE_W+2:0] out_word;

    assign out_word = {o_power_mode, o_kill_tx, o_counters_clear, o_over_temp};

    // no word shows right after reset
    `SPMG_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // stalled word holds
    `SPMG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

    // emergency always clears counters
    `SPMG_ASSERT_NOW(a_kill_clears, i_clk, i_rst_n, o_out_valid && o_kill_tx, o_counters_clear)

    // a counters clear only comes with mode D
    `SPMG_ASSERT_NOW(a_clear_in_d, i_clk, i_rst_n, o_out_valid && o_counters_clear, o_power_mode == MODE_D)

endmodule

bind supply_power_mode_governor spmg_checker u_spmg_checker (.*);

// ===== tb/supply_power_mode_governor_tb.sv =====
module supply_power_mode_governor_tb;
    import spmg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int QUIET_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [VOLT_W-1:0]     i_voltage_sample = '0;
    logic                  i_temp_present = 1'b0;
    logic [TEMP_W-1:0]     i_temp_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [MODE_W-1:0]     o_power_mode;
    logic                  o_kill_tx;
    logic                  o_counters_clear;
    logic                  o_over_temp;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    supply_power_mode_governor u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_voltage_sample (i_voltage_sample),
        .i_temp_present   (i_temp_present),
        .i_temp_sample    (i_temp_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_power_mode     (o_power_mode),
        .o_kill_tx        (o_kill_tx),
        .o_counters_clear (o_counters_clear),
        .o_over_temp      (o_over_temp),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // governor copy: registers and state
    logic [LEVEL_W-1:0] level_q    = LEVEL_RST;
    logic [STEP_W-1:0]  step_q     = STEP_RST;
    logic [VOLT_W-1:0]  fallback_q = FALLBACK_RST;
    logic [MODE_W-1:0]  max_q      = MAX_MODE_RST;
    logic [TEMP_W-1:0]  temp_lim_q = TEMP_LIM_RST;
    t_mode              mode_q     = MODE_RST;
    logic               hot_q      = 1'b0;
    logic               clear_hit;

    t_item   checks_todo[$];
    t_result verdicts_due[$];
    t_item   next_check;
    t_result seen;
    t_result due;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      faults = 0;
    int      quiet_cycles = 0;

    function automatic int cut_below(int k);
        int d;
        d = k * int'(step_q);
        return (d > int'(level_q)) ? 0 : (int'(level_q) - d) * 10;
    endfunction

    function automatic void ask_mode(t_mode req);
        mode_q = (req > max_q) ? t_mode'(max_q) : req;
        if (mode_q == MODE_D)
            clear_hit = 1'b1;
    endfunction

    function automatic t_result govern_check(t_item w);
        t_result r;
        int      v;
        logic    kill;
        v = int'(w.voltage_sample);
        kill = 1'b0;
        clear_hit = 1'b0;
        if (w.temp_present) begin
            hot_q = w.temp_sample > temp_lim_q;
            if (hot_q)
                ask_mode(MODE_D);
        end
        if (v < int'(FAIL_LIMIT))
            v = int'(fallback_q);
        if (v < cut_below(3)) begin
            ask_mode(MODE_D);
            kill = 1'b1;
        end else begin
            case (mode_q)
                MODE_A: begin
                    if (v < cut_below(0))
                        ask_mode(MODE_B);
                end
                MODE_B: begin
                    if (v < cut_below(1))
                        ask_mode(MODE_C);
                    else if (v > (int'(level_q) + int'(step_q)) * 10)
                        ask_mode(MODE_A);
                end
                MODE_C: begin
                    if (v < cut_below(2))
                        ask_mode(MODE_D);
                    else if (v > cut_below(0))
                        ask_mode(MODE_B);
                end
                default: begin
                    if (v > cut_below(1) && !hot_q)
                        ask_mode(MODE_C);
                end
            endcase
        end
        r.power_mode     = mode_q;
        r.kill_tx        = kill;
        r.counters_clear = clear_hit;
        r.over_temp      = hot_q;
        return r;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            faults++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (checks_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_check = checks_todo.pop_front();
                i_in_valid       <= 1'b1;
                i_voltage_sample <= next_check.voltage_sample;
                i_temp_present   <= next_check.temp_present;
                i_temp_sample    <= next_check.temp_sample;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD_LEVEL:   level_q    = i_cfg_data[LEVEL_W-1:0];
                    CFG_THRESHOLD_STEP:    step_q     = i_cfg_data[STEP_W-1:0];
                    CFG_FALLBACK_VOLTAGE:  fallback_q = i_cfg_data[VOLT_W-1:0];
                    CFG_MAX_MODE:          max_q      = i_cfg_data[MODE_W-1:0];
                    CFG_TEMPERATURE_LIMIT: temp_lim_q = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                seen = '{t_mode'(o_power_mode), o_kill_tx, o_counters_clear, o_over_temp};
                if (verdicts_due.size() == 0) begin
                    faults++;
                    $display("%0t unexpected word: mode %0d kill %0d clear %0d hot %0d",
                             $time, seen.power_mode, seen.kill_tx, seen.counters_clear,
                             seen.over_temp);
                end else begin
                    due = verdicts_due.pop_front();
                    check_field("power_mode", due.power_mode, seen.power_mode);
                    check_field("kill_tx", due.kill_tx, seen.kill_tx);
                    check_field("counters_clear", due.counters_clear, seen.counters_clear);
                    check_field("over_temp", due.over_temp, seen.over_temp);
                end
            end
            if (i_in_valid && !o_in_stall)
                verdicts_due.push_back(govern_check(
                    '{i_voltage_sample, i_temp_present, i_temp_sample}));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_one(input int v, input int tp, input int ts);
        checks_todo.push_back('{v[VOLT_W-1:0], tp[0], ts[TEMP_W-1:0]});
    endtask

    // random checks, mostly near the ladder thresholds
    task automatic queue_checks(input int n);
        int r;
        int centre;
        int spread;
        int v;
        int ts;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            centre = int'(level_q) * 10;
            spread = (4 * int'(step_q) + 2) * 10;
            if (r < 8)
                v = $urandom_range(99);
            else if (r < 22)
                v = $urandom_range(65535);
            else begin
                v = centre - spread + $urandom_range(2 * spread);
                if (v < 0)
                    v = $urandom_range(120);
                if (v > 65535)
                    v = 65535;
            end
            if ($urandom_range(99) < 70)
                ts = $urandom_range(int'(temp_lim_q));
            else
                ts = $urandom_range(1023);
            queue_one(v, $urandom_range(1), ts);
        end
    endtask

    // sampled away from the rising edge so driver and monitor updates have landed
    task automatic wait_settled();
        while (checks_todo.size() != 0 || i_in_valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] vals [5];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk over the ladder with reset registers
        queue_one(65535, 0, 0);
        queue_one(355, 0, 0);
        queue_one(371, 0, 0);
        queue_one(359, 0, 0);
        queue_one(349, 0, 0);
        queue_one(361, 0, 0);
        queue_one(345, 0, 0);
        queue_one(339, 0, 0);
        queue_one(351, 0, 0);
        queue_one(329, 0, 0);
        queue_one(0, 0, 0);
        queue_one(99, 0, 0);
        queue_one(100, 0, 0);
        queue_one(400, 1, 1023);
        queue_one(400, 0, 0);
        queue_one(400, 1, 512);
        queue_one(400, 1, 513);
        queue_one(400, 1, 0);
        queue_one(420, 0, 0);
        queue_one(420, 0, 0);
        queue_one(65535, 1, 1023);
        queue_one(360, 1, 0);
        queue_one(360, 0, 1023);
        wait_settled();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: vals = '{16'd0, 16'd0, 16'd0, 16'd3, 16'd0};
                1: vals = '{16'd1000, 16'd100, 16'd65535, 16'd0, 16'd1023};
                2: vals = '{16'd36, 16'd1, 16'd420, 16'd3, 16'd512};
                3: vals = '{16'd500, 16'd20, 16'd4000, 16'd2, 16'd700};
                4: vals = '{16'hFFFF, 16'hFFFF, 16'($urandom), 16'hFFFD, 16'd300};
                5: vals = '{16'd200, 16'd70, 16'd50, 16'd3, 16'd900};
                6: vals = '{16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom)};
                default: vals = '{16'd60, 16'd5, 16'd250, 16'd3, 16'd512};
            endcase
            write_reg(CFG_THRESHOLD_LEVEL, vals[0]);
            write_reg(CFG_THRESHOLD_STEP, vals[1]);
            write_reg(CFG_FALLBACK_VOLTAGE, vals[2]);
            write_reg(CFG_MAX_MODE, vals[3]);
            write_reg(CFG_TEMPERATURE_LIMIT, vals[4]);
            if (p == 6)
                write_reg(CFG_UNUSED_INDEX, 16'($urandom));
            @(posedge i_clk);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 88;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            // pause halfway until every word is back
            queue_checks(45);
            wait_settled();
            queue_checks(45);
            wait_settled();
        end

        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
